### hw/rtl/annexb_pkg.sv
// Shared types and constants for the Annex B NAL unit splitter.
// No dependencies.
package annexb_pkg;

  localparam int WIN_LEN       = 4;
  localparam int MAX_RES       = 5;
  localparam int REC_DEPTH_DEF = 4;

  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // Results produced by one accepted byte, packed from slot 0 up.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [MAX_RES-1:0]      last;
    logic [2:0]              cnt;
  } annexb_rec_t;

endpackage

### hw/rtl/annexb_front.sv
// Front part: look-behind window, start code detection and end-of-buffer flush.
// Emits one result record per accepted byte that yields output. Uses annexb_pkg.
module annexb_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [7:0]              in_byte,
  input  logic                    in_end_of_buffer,
  output logic                    rec_valid,
  output annexb_pkg::annexb_rec_t rec
);
  import annexb_pkg::*;

  logic [WIN_LEN-1:0][7:0] win_r, win_nxt, win_a;
  logic [2:0]              fill_r, fill_nxt, fill_after, fill_mid, fl_cnt;
  logic                    inside_r, inside_nxt, inside_mid;
  logic                    have_ev, ev_out, sc;
  logic [7:0]              evicted;

  always_comb begin
    have_ev    = (fill_r == 3'(WIN_LEN));
    evicted    = win_r[0];
    win_a      = win_r;
    fill_after = fill_r + 3'd1;
    if (have_ev) begin
      for (int i = 0; i < WIN_LEN - 1; i++) win_a[i] = win_r[i+1];
      win_a[WIN_LEN-1] = in_byte;
      fill_after       = 3'(WIN_LEN);
    end else begin
      win_a[fill_r[1:0]] = in_byte;
    end

    sc = (fill_after == 3'(WIN_LEN)) && (win_a[0] == SC_ZERO) && (win_a[1] == SC_ZERO) &&
         (win_a[2] == SC_ZERO) && (win_a[3] == SC_ONE);

    ev_out     = have_ev && inside_r;
    inside_mid = sc ? 1'b1 : inside_r;
    fill_mid   = sc ? 3'd0 : fill_after;
    fl_cnt     = (in_end_of_buffer && inside_mid) ? fill_mid : 3'd0;

    rec = '0;
    if (ev_out) begin
      rec.bytes[0] = evicted;
      rec.last[0]  = sc;
      for (int i = 0; i < WIN_LEN; i++) begin
        rec.bytes[i+1] = win_a[i];
        rec.last[i+1]  = (3'(i + 1) == fl_cnt);
      end
    end else begin
      for (int i = 0; i < WIN_LEN; i++) begin
        rec.bytes[i] = win_a[i];
        rec.last[i]  = (3'(i + 1) == fl_cnt);
      end
    end
    rec.cnt   = fl_cnt + {2'b00, ev_out};
    rec_valid = accept && (rec.cnt != 3'd0);

    if (in_end_of_buffer) begin
      win_nxt    = '0;
      fill_nxt   = 3'd0;
      inside_nxt = 1'b0;
    end else begin
      win_nxt    = win_a;
      fill_nxt   = fill_mid;
      inside_nxt = inside_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      fill_r   <= 3'd0;
      inside_r <= 1'b0;
    end else if (accept) begin
      win_r    <= win_nxt;
      fill_r   <= fill_nxt;
      inside_r <= inside_nxt;
    end
  end

endmodule

### hw/rtl/annexb_queue.sv
// Record queue between front and back parts, flip-flop storage, head read direct.
// Uses annexb_pkg for the record type.
module annexb_queue #(
  parameter int DEPTH = annexb_pkg::REC_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  annexb_pkg::annexb_rec_t wr_data,
  output logic                    full,
  input  logic                    rd_en,
  output annexb_pkg::annexb_rec_t rd_data,
  output logic                    empty
);
  import annexb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  annexb_rec_t       mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (do_wr && !do_rd) count_nxt = count_r + CW'(1);
    else if (do_rd && !do_wr) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hw/rtl/annexb_back.sv
// Back part: walks the head record one byte per cycle into the output register
// when that register is empty or popped. Uses annexb_pkg for the record type.
module annexb_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  annexb_pkg::annexb_rec_t head,
  input  logic                    q_empty,
  output logic                    q_rd,
  input  logic                    pop,
  output logic                    empty,
  output logic [7:0]              out_byte,
  output logic                    out_last_of_nal
);
  import annexb_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       load, take, last_slot;

  assign empty           = !out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_nal = out_last_r;

  always_comb begin
    load          = !out_valid_r || pop;
    take          = load && !q_empty;
    last_slot     = (idx_r == head.cnt - 3'd1);
    q_rd          = take && last_slot;
    idx_nxt       = idx_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !pop;
    if (take) begin
      idx_nxt       = last_slot ? 3'd0 : idx_r + 3'd1;
      out_byte_nxt  = head.bytes[idx_r];
      out_last_nxt  = head.last[idx_r];
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/annexb_nal_unit_splitter.sv
// Top level of the Annex B NAL unit splitter.
// Instantiates annexb_front, annexb_queue and annexb_back; uses annexb_pkg.
//
// Splits a byte stream at 00 00 00 01 start codes, one input byte per clock
// while full is low. Each payload byte leaves with last_of_nal set on the
// final byte of its unit; bytes ahead of a buffer's first start code and
// empty units produce nothing, and every buffer end flushes and closes the
// open unit. Each result byte stays in the output register until popped, so
// a flush at a buffer end can yield up to five output bytes. A queue
// of REC_DEPTH records (each the output of one input byte) sits between the
// window logic and the output walker, and full rises only when it fills.
// Each result is stored in the queue, then in the output register.
// REC_DEPTH must be at least 2.
module annexb_nal_unit_splitter #(
  parameter int REC_DEPTH = annexb_pkg::REC_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_buffer,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last_of_nal
);
  import annexb_pkg::*;

  annexb_rec_t rec, head;
  logic        accept, rec_valid, q_empty, q_rd;

  assign accept = push && !full;

  annexb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .in_byte          (in_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .rec_valid        (rec_valid),
    .rec              (rec)
  );

  annexb_queue #(
    .DEPTH (REC_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rec_valid),
    .wr_data (rec),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (head),
    .empty   (q_empty)
  );

  annexb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_empty),
    .q_rd            (q_rd),
    .pop             (pop),
    .empty           (empty),
    .out_byte        (out_byte),
    .out_last_of_nal (out_last_of_nal)
  );

endmodule
